>>> hw/rtl/cbdc_pkg.sv
// Package for the colour box classifier with dwell counter.
// Holds request codes, field widths, parameter defaults and the counter wrap helper.
// No dependencies; every other file of the block refers to it by scoped names.
package cbdc_pkg;

  // Parameter defaults for the top level.
  localparam int unsigned NumClassesDef = 5;
  localparam int unsigned SampleBitsDef = 16;
  localparam int unsigned CountLimitDef = 99;

  // Fixed field widths.
  localparam int unsigned LevelW   = 16;
  localparam int unsigned BoundIdxW = 5;
  localparam int unsigned TpcW     = 8;
  localparam int unsigned CntW     = 7;
  localparam int unsigned ClassW   = 4;  // holds class codes for up to 15 boxes
  localparam int unsigned ColorW   = 3;
  localparam int unsigned OutSlots = 5;  // counter fields present on the result

  // Stream payload widths, padded to whole bytes.
  localparam int unsigned InDataW  = 72;
  localparam int unsigned InUserW  = 8;
  localparam int unsigned OutDataW = 48;

  // Reset value of the dwell threshold register.
  localparam logic [TpcW-1:0] TpcReset = 8'd20;

  typedef enum logic [1:0] {
    REQ_SAMPLE = 2'd0,
    REQ_TICK   = 2'd1,
    REQ_CLEAR  = 2'd2,
    REQ_WRITE  = 2'd3
  } req_e;

  // Counters run 1..limit and wrap from the limit back to 1.
  function automatic logic [CntW-1:0] wrap_inc(input logic [CntW-1:0] c,
                                               input logic [CntW-1:0] limit);
    logic [CntW-1:0] r;
    if (c >= limit) begin
      r = CntW'(1);
    end else begin
      r = c + CntW'(1);
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/color_box_classifier_dwell_counter.sv
// Top level of the colour box classifier with dwell counter.
// Depends on cbdc_pkg for request codes, widths and the counter wrap helper.
//
// The block takes one transaction per clock cycle on the slave stream
// unless a stalled result holds it off, and returns exactly one result
// transaction for each. A request first lands in an input register; once
// it can move on, the classification, the dwell timer and the counters are
// evaluated by short combinational logic and the result is captured in the
// output register. The throughput of one request per cycle, unless stalled,
// is set by that single pass: every request reads the state left by the one
// before it and updates it as it moves into the output register. The input
// ready follows the output side: a request is taken whenever the input
// register is empty or its content can move on in the same cycle, which
// includes a waiting result being taken. The bound table sits in flip-flops
// and is cleared by reset, so no box matches until bounds are written; a
// bound write with an index past the table is dropped. The dwell threshold
// register is written through its own channel, which is always ready, and
// must only be written while no request is in flight.
module color_box_classifier_dwell_counter #(
  parameter int unsigned NUM_CLASSES = cbdc_pkg::NumClassesDef,
  parameter int unsigned SAMPLE_BITS = cbdc_pkg::SampleBitsDef,
  parameter int unsigned COUNT_LIMIT = cbdc_pkg::CountLimitDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write channel: dwell threshold in ticks.
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [cbdc_pkg::TpcW-1:0]     cfg_data_i,
  // Request stream.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // tdata from bit 0: red_level[15:0], green_level[31:16], blue_level[47:32],
  // bound_index[52:48], bound_value[68:53], zero padding[71:69].
  input  logic [cbdc_pkg::InDataW-1:0]  s_axis_tdata,
  // tuser from bit 0: req_type[1:0], zero padding[7:2].
  input  logic [cbdc_pkg::InUserW-1:0]  s_axis_tuser,
  // Result stream.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // tdata from bit 0: color_class[2:0], counted[3], count_red[10:4],
  // count_green[17:11], count_yellow[24:18], count_purple[31:25],
  // count_orange[38:32], count_total[45:39], zero padding[47:46].
  output logic [cbdc_pkg::OutDataW-1:0] m_axis_tdata
);

  localparam int unsigned LevelW = cbdc_pkg::LevelW;
  localparam int unsigned CntW   = cbdc_pkg::CntW;
  localparam int unsigned ClassW = cbdc_pkg::ClassW;
  localparam int unsigned TpcW   = cbdc_pkg::TpcW;
  // Bounds and readings are compared on this many low bits.
  localparam int unsigned EffW   = (SAMPLE_BITS < LevelW) ? SAMPLE_BITS : LevelW;
  localparam int unsigned Depth  = NUM_CLASSES * 6;
  localparam int unsigned TabIdxW = $clog2(Depth);
  localparam logic [CntW-1:0] Limit = CntW'(COUNT_LIMIT);

  // ---------------------------------------------------------------------------
  // Handshake: input register feeds the output register.
  // ---------------------------------------------------------------------------
  logic in_valid_q;
  logic out_valid_q;
  logic advance;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign m_axis_tvalid = out_valid_q;
  assign cfg_ready_o   = 1'b1;

  // Input register payload.
  cbdc_pkg::req_e              in_req_q;
  logic [LevelW-1:0]           in_lvl_q [3];
  logic [cbdc_pkg::BoundIdxW-1:0] in_idx_q;
  logic [LevelW-1:0]           in_val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_req_q    <= cbdc_pkg::req_e'(s_axis_tuser[1:0]);
      in_lvl_q[0] <= s_axis_tdata[15:0];
      in_lvl_q[1] <= s_axis_tdata[31:16];
      in_lvl_q[2] <= s_axis_tdata[47:32];
      in_idx_q    <= s_axis_tdata[52:48];
      in_val_q    <= s_axis_tdata[68:53];
    end
  end

  // ---------------------------------------------------------------------------
  // State.
  // ---------------------------------------------------------------------------
  logic [TpcW-1:0]   tpc_q;
  logic [EffW-1:0]   bound_q [Depth];
  logic [ClassW-1:0] last_q, last_d;
  logic [7:0]        dwell_q, dwell_d;
  logic              run_q, run_d;
  logic [CntW-1:0]   cnt_q [NUM_CLASSES];
  logic [CntW-1:0]   cnt_d [NUM_CLASSES];
  logic [CntW-1:0]   total_q, total_d;
  logic              counted;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpc_q <= cbdc_pkg::TpcReset;
    end else if (cfg_valid_i) begin
      tpc_q <= cfg_data_i;
    end
  end

  // Bound writes; an index past the table is dropped.
  logic bound_we;
  assign bound_we = advance && (in_req_q == cbdc_pkg::REQ_WRITE) &&
                    (32'(in_idx_q) < 32'(Depth));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) begin
        bound_q[i] <= '0;
      end
    end else if (bound_we) begin
      bound_q[TabIdxW'(in_idx_q)] <= in_val_q[EffW-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Classification: each box tests the three channels strictly inside its
  // bounds; the lowest-numbered matching box wins.
  // ---------------------------------------------------------------------------
  logic [NUM_CLASSES-1:0] box_hit;
  logic [ClassW-1:0]      cls;

  always_comb begin
    for (int k = 0; k < NUM_CLASSES; k++) begin
      box_hit[k] = 1'b1;
      for (int ch = 0; ch < 3; ch++) begin
        if (!((in_lvl_q[ch][EffW-1:0] > bound_q[k*6 + ch*2]) &&
              (in_lvl_q[ch][EffW-1:0] < bound_q[k*6 + ch*2 + 1]))) begin
          box_hit[k] = 1'b0;
        end
      end
    end
    cls = '0;
    for (int k = NUM_CLASSES - 1; k >= 0; k--) begin
      if (box_hit[k]) begin
        cls = ClassW'(k + 1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Dwell timer and counters.
  // ---------------------------------------------------------------------------
  logic [7:0] dwell_inc;
  logic       dwell_done;

  assign dwell_inc  = dwell_q + 8'd1;
  // A zero threshold fires when the dwell count wraps, after 256 ticks.
  assign dwell_done = (dwell_inc == tpc_q);

  always_comb begin
    last_d  = last_q;
    dwell_d = dwell_q;
    run_d   = run_q;
    total_d = total_q;
    counted = 1'b0;
    for (int k = 0; k < NUM_CLASSES; k++) begin
      cnt_d[k] = cnt_q[k];
    end
    case (in_req_q)
      cbdc_pkg::REQ_SAMPLE: begin
        if (cls != last_q) begin
          run_d   = 1'b0;
          dwell_d = '0;
        end else begin
          run_d = 1'b1;
        end
        last_d = cls;
      end
      cbdc_pkg::REQ_TICK: begin
        if (run_q) begin
          if (dwell_done) begin
            dwell_d = '0;
            run_d   = 1'b0;
            // An unknown colour only restarts the dwell.
            if (last_q != '0) begin
              counted = 1'b1;
              total_d = cbdc_pkg::wrap_inc(total_q, Limit);
              for (int k = 0; k < NUM_CLASSES; k++) begin
                if (last_q == ClassW'(k + 1)) begin
                  cnt_d[k] = cbdc_pkg::wrap_inc(cnt_q[k], Limit);
                end
              end
            end
          end else begin
            dwell_d = dwell_inc;
          end
        end
      end
      cbdc_pkg::REQ_CLEAR: begin
        dwell_d = '0;
        run_d   = 1'b0;
        total_d = '0;
        for (int k = 0; k < NUM_CLASSES; k++) begin
          cnt_d[k] = '0;
        end
      end
      default: begin
        // Bound writes leave the classifier state alone.
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q  <= '0;
      dwell_q <= '0;
      run_q   <= 1'b0;
      total_q <= '0;
      for (int k = 0; k < NUM_CLASSES; k++) begin
        cnt_q[k] <= '0;
      end
    end else if (advance) begin
      last_q  <= last_d;
      dwell_q <= dwell_d;
      run_q   <= run_d;
      total_q <= total_d;
      for (int k = 0; k < NUM_CLASSES; k++) begin
        cnt_q[k] <= cnt_d[k];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result register. Counter fields of absent boxes read as zero.
  // ---------------------------------------------------------------------------
  logic [CntW-1:0] slot [cbdc_pkg::OutSlots];

  for (genvar i = 0; i < cbdc_pkg::OutSlots; i++) begin : g_slot
    if (i < NUM_CLASSES) begin : g_on
      assign slot[i] = cnt_d[i];
    end else begin : g_off
      assign slot[i] = '0;
    end
  end

  logic [cbdc_pkg::OutDataW-1:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= {2'b00, total_d, slot[4], slot[3], slot[2], slot[1], slot[0],
                     counted, last_d[cbdc_pkg::ColorW-1:0]};
    end
  end

  assign m_axis_tdata = out_data_q;

endmodule

>>> hw/rtl/cbdc_checker.sv
// Port-level checker for the colour box classifier with dwell counter.
// Depends on cbdc_pkg for widths; bound to the top level at the end of this file.
module cbdc_checker #(
  parameter int unsigned COUNT_LIMIT = cbdc_pkg::CountLimitDef
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [cbdc_pkg::OutDataW-1:0] m_axis_tdata
);

  logic [cbdc_pkg::CntW-1:0] lim;
  assign lim = cbdc_pkg::CntW'(COUNT_LIMIT);

  // A stalled result transaction holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Requests are only held off while a result waits downstream.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output back-pressure");

  // A count is only made for a known colour, and it leaves the total nonzero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[3] |->
      (m_axis_tdata[2:0] != 3'd0) && (m_axis_tdata[45:39] != 7'd0))
    else $error("count reported for unknown colour or with zero total");

  // Counters never pass their wrap limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[45:39] <= lim) && (m_axis_tdata[10:4] <= lim) &&
      (m_axis_tdata[17:11] <= lim) && (m_axis_tdata[24:18] <= lim) &&
      (m_axis_tdata[31:25] <= lim) && (m_axis_tdata[38:32] <= lim))
    else $error("counter above wrap limit");

endmodule

bind color_box_classifier_dwell_counter cbdc_checker #(
  .COUNT_LIMIT(COUNT_LIMIT)
) u_cbdc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
